// ----- hdl/u8s_pkg.sv -----
package u8s_pkg;

   // replacement for any byte that cannot stand in a well-formed sequence
   localparam logic [7:0] SubChar   = 8'h3F;
   localparam logic [7:0] AsciiMax  = 8'h7F;
   localparam logic [7:0] Lead2Min  = 8'hC0;
   localparam logic [7:0] Lead2Max  = 8'hDF;
   localparam logic [7:0] Lead3Max  = 8'hEF;
   localparam logic [7:0] Lead4Max  = 8'hF7;
   localparam logic [1:0] ContTag   = 2'b10;

   // at most three replacements plus one byte come from one item
   localparam int unsigned BurstMax = 4;

   // one queue entry: the output bytes that one item causes, in order
   typedef struct packed {
      logic [BurstMax-1:0][7:0] bytes;
      logic [2:0]               count;  // 1..4
      logic                     last;   // string end flag of the causing item
   } burst_type;

endpackage

// ----- hdl/u8s_if.sv -----
interface u8s_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface u8s_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ----- hdl/u8s_front.sv -----
module u8s_front (
   input  logic               clock,
   input  logic               reset,
   u8s_req_if.sink            req_chan,
   input  logic               q_full,
   output logic               q_push,
   output u8s_pkg::burst_type q_data
);
   import u8s_pkg::*;

   typedef enum logic [1:0] {ClsAscii, ClsLead, ClsCont, ClsBad} class_type;

   logic [2:0][7:0] held_ff, held_in;
   logic [1:0]      count_ff, count_in;
   logic [1:0]      need_ff, need_in;
   class_type       cls;
   burst_type       burst;
   logic [1:0]      pre;
   logic            fresh;
   logic            accept;

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      if (req_chan.in_byte <= AsciiMax) begin
         cls = ClsAscii;
      end else if (req_chan.in_byte[7:6] == ContTag) begin
         cls = ClsCont;
      end else if (req_chan.in_byte >= Lead2Min && req_chan.in_byte <= Lead4Max) begin
         cls = ClsLead;
      end else begin
         cls = ClsBad;
      end
   end

   always_comb begin
      held_in     = held_ff;
      count_in    = count_ff;
      need_in     = need_ff;
      burst.bytes = {BurstMax{SubChar}};
      burst.count = 3'd0;
      burst.last  = req_chan.in_last;
      pre         = 2'd0;
      fresh       = 1'b1;

      if (count_ff != 2'd0) begin
         if (cls == ClsCont) begin
            fresh = 1'b0;
            if (count_ff == need_ff) begin
               // sequence complete: held bytes then this one
               for (int i = 0; i < 3; i++) begin
                  if (2'(i) < count_ff) burst.bytes[i] = held_ff[i];
               end
               burst.bytes[count_ff] = req_chan.in_byte;
               burst.count           = {1'b0, count_ff} + 3'd1;
               count_in              = 2'd0;
            end else if (req_chan.in_last || count_ff == 2'd3) begin
               // string ends inside the sequence
               burst.count = {1'b0, count_ff} + 3'd1;
               count_in    = 2'd0;
            end else begin
               unique case (count_ff)
                  2'd1:    held_in[1] = req_chan.in_byte;
                  2'd2:    held_in[2] = req_chan.in_byte;
                  default: ;
               endcase
               count_in = count_ff + 2'd1;
            end
         end else begin
            // early break: held bytes become replacements
            pre      = count_ff;
            count_in = 2'd0;
         end
      end

      if (fresh) begin
         unique case (cls)
            ClsAscii: begin
               burst.bytes[pre] = req_chan.in_byte;
               burst.count      = {1'b0, pre} + 3'd1;
            end
            ClsLead: begin
               if (req_chan.in_last) begin
                  burst.count = {1'b0, pre} + 3'd1;
               end else begin
                  held_in[0]  = req_chan.in_byte;
                  count_in    = 2'd1;
                  burst.count = {1'b0, pre};
                  if (req_chan.in_byte <= Lead2Max) begin
                     need_in = 2'd1;
                  end else if (req_chan.in_byte <= Lead3Max) begin
                     need_in = 2'd2;
                  end else begin
                     need_in = 2'd3;
                  end
               end
            end
            default: begin
               burst.count = {1'b0, pre} + 3'd1;
            end
         endcase
      end
   end

   assign q_push = accept && (burst.count != 3'd0);
   assign q_data = burst;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         need_ff  <= 2'd0;
      end else if (accept) begin
         count_ff <= count_in;
         need_ff  <= need_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

endmodule

// ----- hdl/u8s_queue.sv -----
module u8s_queue #(
   parameter int unsigned Depth = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  u8s_pkg::burst_type push_data,
   input  logic               pop,
   output u8s_pkg::burst_type pop_data,
   output logic               not_empty,
   output logic               full
);
   import u8s_pkg::*;

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   burst_type           slot_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CntW'(Depth));
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hdl/u8s_back.sv -----
module u8s_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_not_empty,
   input  u8s_pkg::burst_type q_data,
   output logic               q_pop,
   u8s_rsp_if.source          rsp_chan
);
   import u8s_pkg::*;

   logic       busy_ff, busy_in;
   burst_type  burst_ff, burst_in;
   logic [1:0] idx_ff, idx_in;
   logic [1:0] last_idx;
   logic       final_byte;
   logic       take;

   assign last_idx   = 2'(burst_ff.count - 3'd1);
   assign final_byte = (idx_ff == last_idx);
   assign take       = busy_ff && rsp_chan.ready;

   // refill as soon as the current burst drains, so bursts follow without a gap
   assign q_pop = q_not_empty && (!busy_ff || (take && final_byte));

   assign rsp_chan.valid    = busy_ff;
   assign rsp_chan.out_byte = burst_ff.bytes[idx_ff];
   assign rsp_chan.out_last = burst_ff.last && final_byte;

   always_comb begin
      busy_in  = busy_ff;
      burst_in = burst_ff;
      idx_in   = idx_ff;
      if (q_pop) begin
         busy_in  = 1'b1;
         burst_in = q_data;
         idx_in   = 2'd0;
      end else if (take) begin
         if (final_byte) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      burst_ff <= burst_in;
   end

endmodule

// ----- hdl/utf8_byte_sanitizer_top.sv -----
// Path: each item's result bytes pass through the burst queue and the back's burst register before rsp.
// Throughput: one item per cycle at the input; one result byte per cycle at the output while rsp is ready.
// An item may cause up to four result bytes; the burst queue soaks these up, and req
// stalls only when the queue is full and the output side is behind.
// Reset: synchronous, active high; clears the held sequence, the queue and the output.
module utf8_byte_sanitizer_top #(
   parameter int unsigned QueueDepth = 4
) (
   input  logic       clock,
   input  logic       reset,
   u8s_req_if.sink    req_chan,
   u8s_rsp_if.source  rsp_chan
);
   import u8s_pkg::*;

   // front -> queue
   logic      q_push;
   burst_type q_push_data;
   logic      q_full;

   // queue -> back
   logic      q_pop;
   burst_type q_pop_data;
   logic      q_not_empty;

   // Front: classifies each byte against the held partial sequence and turns it
   // into a burst of zero to four output bytes.
   u8s_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_push_data)
   );

   // Burst queue decouples the input rate from the burst output.
   u8s_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   // Back: plays out each burst one byte per cycle while rsp is ready, flagging the string end.
   u8s_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_data      (q_pop_data),
      .q_pop       (q_pop),
      .rsp_chan    (rsp_chan)
   );

   // no write into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("burst queue overflow");

   // no read from an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_not_empty)
      else $error("burst queue underflow");

   // output is quiet right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("result valid after reset");

   // every queued burst holds one to four bytes
   a_burst_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_push_data.count != 3'd0) && (q_push_data.count <= 3'd4))
      else $error("bad burst length");

endmodule

// ----- dv/tb_utf8_byte_sanitizer_top.sv -----
`timescale 1ns / 100ps

module tb_utf8_byte_sanitizer_top;
   import u8s_pkg::*;

   // random part size, and the lengths of the special phases inside it
   localparam int RandomItems  = 75;
   localparam int PressureRun  = 30;
   localparam int QuietRun     = 15;
   // receiver hold-off that fills the burst queue and stalls req
   localparam int HoldCycles   = 60;
   // the queue holds four bursts, so this is plenty
   localparam int DrainCycles  = 16;
   localparam int MaxReports   = 10;
   localparam int DirectedRows = 25;

   // one sanitized output byte as seen on rsp
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } out_item_type;

   // one directed row; typed rows carry the output bytes in order, and the
   // last flag goes on the final one when the row's in_last is set
   typedef struct packed {
      logic [7:0]      in_byte;
      logic            in_last;
      logic            typed;
      logic [2:0]      exp_n;
      logic [0:3][7:0] exp_bytes;
   } stim_row_type;

   localparam logic [0:3][7:0] NoBytes = '0;

   logic clock;
   logic reset;

   u8s_req_if req_bus ();
   u8s_rsp_if rsp_bus ();

   utf8_byte_sanitizer_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Directed items. Rows marked typed have their output read straight off the
   // rules (pass-through, replacement, lead at end, early break, end inside a
   // sequence); the others, complete sequences and a break by a new lead, are left to the predictor.
   stim_row_type directed_rows [DirectedRows] = '{
      // extremes of ASCII, pass through
      '{8'h00, 1'b0, 1'b1, 3'd1, {8'h00, 8'h00, 8'h00, 8'h00}},
      '{8'h7F, 1'b1, 1'b1, 3'd1, {8'h7F, 8'h00, 8'h00, 8'h00}},
      // stray continuation, then bytes that can never lead
      '{8'h80, 1'b0, 1'b1, 3'd1, {SubChar, 8'h00, 8'h00, 8'h00}},
      '{8'hF8, 1'b0, 1'b1, 3'd1, {SubChar, 8'h00, 8'h00, 8'h00}},
      '{8'hFF, 1'b1, 1'b1, 3'd1, {SubChar, 8'h00, 8'h00, 8'h00}},
      // multi-byte lead flagged last
      '{8'hC0, 1'b1, 1'b1, 3'd1, {SubChar, 8'h00, 8'h00, 8'h00}},
      // well-formed 2, 3 and 4 byte sequences
      '{8'hC2, 1'b0, 1'b0, 3'd0, NoBytes},
      '{8'hA9, 1'b0, 1'b0, 3'd0, NoBytes},
      '{8'hE2, 1'b0, 1'b0, 3'd0, NoBytes},
      '{8'h82, 1'b0, 1'b0, 3'd0, NoBytes},
      '{8'hAC, 1'b0, 1'b0, 3'd0, NoBytes},
      '{8'hF0, 1'b0, 1'b0, 3'd0, NoBytes},
      '{8'h9F, 1'b0, 1'b0, 3'd0, NoBytes},
      '{8'h98, 1'b0, 1'b0, 3'd0, NoBytes},
      '{8'h80, 1'b1, 1'b0, 3'd0, NoBytes},
      // early break by an ASCII byte
      '{8'hE0, 1'b0, 1'b1, 3'd0, NoBytes},
      '{8'h41, 1'b1, 1'b1, 3'd2, {SubChar, 8'h41, 8'h00, 8'h00}},
      // string ends inside a 4-byte sequence
      '{8'hF7, 1'b0, 1'b1, 3'd0, NoBytes},
      '{8'h80, 1'b0, 1'b1, 3'd0, NoBytes},
      '{8'h80, 1'b1, 1'b1, 3'd3, {SubChar, SubChar, SubChar, 8'h00}},
      // early break by a new lead, which then completes
      '{8'hDF, 1'b0, 1'b0, 3'd0, NoBytes},
      '{8'hF4, 1'b0, 1'b0, 3'd0, NoBytes},
      '{8'h8F, 1'b0, 1'b0, 3'd0, NoBytes},
      '{8'h8F, 1'b0, 1'b0, 3'd0, NoBytes},
      '{8'hBF, 1'b1, 1'b0, 3'd0, NoBytes}
   };

   // predictor state: the held sequence
   logic [7:0] seq_bytes [3];
   int         seq_count;     // bytes held, lead included; 0 = idle
   int         seq_need;      // continuations the held lead needs

   logic [7:0]   staged_bytes [$];  // output bytes of the item just accepted
   logic [7:0]   text_bytes [$];    // random string under construction
   out_item_type sanitized_q [$];   // expected rsp items, oldest first

   int bad_count;
   int random_sent;
   bit hold_request;  // asks the receiver for one long hold-off
   bit no_gaps;       // sender and receiver both run without idling

   // 2 ns clock
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // generous bound on the whole run
   initial begin
      #1_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // mostly back-to-back, some short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      if (no_gaps)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // one more output byte for the item just accepted
   function automatic void stage_out(input logic [7:0] b);
      staged_bytes.insert(staged_bytes.size(), b);
   endfunction

   // one more byte of the random string
   function automatic void add_text(input logic [7:0] b);
      text_bytes.insert(text_bytes.size(), b);
   endfunction

   // Works out the output bytes of one accepted item into staged_bytes and
   // advances the held sequence.
   function automatic void sanitize_byte(input logic [7:0] b, input logic l);
      staged_bytes.delete();
      if (seq_count != 0) begin
         if (b[7:6] == ContTag) begin
            if (seq_count == seq_need) begin
               // sequence complete, emit it whole
               for (int i = 0; i < seq_count; i++)
                  stage_out(seq_bytes[i]);
               stage_out(b);
               seq_count = 0;
            end else if (l) begin
               // string ends inside the sequence
               for (int i = 0; i <= seq_count; i++)
                  stage_out(SubChar);
               seq_count = 0;
            end else begin
               seq_bytes[seq_count] = b;
               seq_count++;
            end
            return;
         end
         // early break: flush the held bytes, then treat b as new
         for (int i = 0; i < seq_count; i++)
            stage_out(SubChar);
         seq_count = 0;
      end
      if (b <= AsciiMax) begin
         stage_out(b);
      end else if (b >= Lead2Min && b <= Lead4Max) begin
         if (l) begin
            stage_out(SubChar);
         end else begin
            seq_bytes[0] = b;
            seq_count    = 1;
            seq_need     = (b <= Lead2Max) ? 1 : (b <= Lead3Max) ? 2 : 3;
         end
      end else begin
         stage_out(SubChar);
      end
   endfunction

   // staged bytes become expected rsp items; last rides on the final one
   function automatic void queue_staged(input logic l);
      out_item_type entry;
      foreach (staged_bytes[k]) begin
         entry.data = staged_bytes[k];
         entry.last = l && (k == staged_bytes.size() - 1);
         sanitized_q.insert(sanitized_q.size(), entry);
      end
   endfunction

   // Offers one item after a random gap and waits for the handshake. Ready is
   // sampled at the rising edge, before any register update in that step.
   task automatic send_item(input logic [7:0] b, input logic l);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.in_byte <= b;
      req_bus.in_last <= l;
      do @(posedge clock); while (!req_bus.ready);
      sanitize_byte(b, l);
   endtask

   // Appends one character of the given length; keep < len truncates it.
   task automatic append_char(input int len, input int keep);
      logic [7:0] lead;
      case (len)
         1: lead = 8'($urandom_range(0, AsciiMax));
         2: lead = 8'($urandom_range(Lead2Min, Lead2Max));
         3: lead = 8'($urandom_range(Lead2Max + 1, Lead3Max));
         default: lead = 8'($urandom_range(Lead3Max + 1, Lead4Max));
      endcase
      if (keep > 0)
         add_text(lead);
      for (int k = 1; k < keep; k++)
         add_text({ContTag, 6'($urandom_range(0, 63))});
   endtask

   // One random string: mostly well-formed characters with random content,
   // some truncated sequences, stray continuations and arbitrary bytes.
   // Its final byte is flagged last.
   task automatic send_string();
      int n_chars;
      int roll;
      int len;
      text_bytes.delete();
      n_chars = $urandom_range(1, 6);
      for (int c = 0; c < n_chars; c++) begin
         roll = $urandom_range(0, 99);
         if (roll < 75) begin
            len = $urandom_range(1, 4);
            append_char(len, len);
         end else if (roll < 88) begin
            len = $urandom_range(2, 4);
            append_char(len, $urandom_range(1, len - 1));
         end else if (roll < 94) begin
            add_text({ContTag, 6'($urandom_range(0, 63))});
         end else begin
            add_text(8'($urandom_range(0, 255)));
         end
      end
      foreach (text_bytes[k]) begin
         send_item(text_bytes[k], k == text_bytes.size() - 1);
         queue_staged(k == text_bytes.size() - 1);
         random_sent++;
      end
   endtask

   // drop valid and wait until every expected item has come out
   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sanitized_q.size() != 0) @(posedge clock);
   endtask

   // Receiver: random stalls, plus the one long hold-off on request, which
   // it counts out itself while the sender keeps offering.
   initial begin
      int stall_left;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HoldCycles) @(negedge clock);
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   // Checker: every rsp item against the oldest expectation.
   always @(posedge clock) begin
      out_item_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (sanitized_q.size() == 0) begin
            bad_count++;
            if (bad_count <= MaxReports)
               $display("unexpected output %02h last %0b", rsp_bus.out_byte,
                        rsp_bus.out_last);
         end else begin
            want = sanitized_q.pop_front();
            if (rsp_bus.out_byte !== want.data || rsp_bus.out_last !== want.last) begin
               bad_count++;
               if (bad_count <= MaxReports)
                  $display("mismatch: expected %02h last %0b, got %02h last %0b",
                           want.data, want.last, rsp_bus.out_byte, rsp_bus.out_last);
            end
         end
      end
   end

   // Stimulus: reset, directed rows, then random strings with a pressure
   // phase, a full pause, and a stretch without idling.
   initial begin
      req_bus.valid   = 1'b0;
      req_bus.in_byte = 8'h00;
      req_bus.in_last = 1'b0;
      reset           = 1'b1;
      seq_count       = 0;
      seq_need        = 0;
      bad_count       = 0;
      random_sent     = 0;
      hold_request    = 1'b0;
      no_gaps         = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         send_item(directed_rows[r].in_byte, directed_rows[r].in_last);
         // typed rows replace the predicted bytes with the hand-written ones
         if (directed_rows[r].typed) begin
            staged_bytes.delete();
            for (int k = 0; k < directed_rows[r].exp_n; k++)
               stage_out(directed_rows[r].exp_bytes[k]);
         end
         queue_staged(directed_rows[r].in_last);
      end

      while (random_sent < RandomItems / 3) send_string();

      // receiver holds off while items arrive back to back: the burst queue
      // fills and req must stall
      hold_request = 1'b1;
      no_gaps      = 1'b1;
      while (random_sent < RandomItems / 3 + PressureRun) send_string();
      no_gaps = 1'b0;

      // sender waits for the block to empty out completely
      drain();

      // a stretch with no idling on either side
      no_gaps = 1'b1;
      while (random_sent < RandomItems / 3 + PressureRun + QuietRun) send_string();
      no_gaps = 1'b0;

      while (random_sent < RandomItems) send_string();

      drain();
      repeat (DrainCycles) @(posedge clock);
      if (bad_count == 0 && sanitized_q.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/u8s_pkg.sv
hdl/u8s_if.sv
hdl/u8s_front.sv
hdl/u8s_queue.sv
hdl/u8s_back.sv
hdl/utf8_byte_sanitizer_top.sv
dv/tb_utf8_byte_sanitizer_top.sv
